// File: design/mrt_pkg.sv
// Package for the masked route table: item kinds, status codes, sequencer
// states and the stored entry and result layouts. No dependencies.
`default_nettype none

package mrt_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PORT_W = 4;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned S_TDATA_W = 136;
    localparam int unsigned M_TDATA_W = 40;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SHIFT,
        S_SCAN,
        S_SEND
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } entry_t;

    typedef struct packed {
        logic              found;
        logic [PORT_W-1:0] out_port;
        logic [ADDR_W-1:0] next_hop;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

// File: design/masked_route_table_core.sv
// Masked route table top level: stream ports, sequencer and result register.
// Depends on mrt_pkg, mrt_store and mrt_match.
//
// An ordered IPv4 route table of TABLE_DEPTH entries with first-match lookup.
// One transaction on the slave side gives exactly one result transaction on
// the master side. The block takes one transaction at a time: s_axis_tready
// is high only while the sequencer is idle. Add, clear and refused
// transactions go from dispatch straight to the send state. A lookup
// walks the entries from position 0 through the single read port of the
// entry store and the shared masked compare unit, one entry per cycle, and
// stops at the first hit or after the last entry. A remove moves the later
// entries down one per cycle through that same read port and the write
// port. The master side holds a registered result, so a waiting result
// only stalls the block when the next result is ready to leave. Stored
// entries are not cleared at reset; only positions below the entry count
// are ever used.
`default_nettype none

module masked_route_table_core
    import mrt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // slave side
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // mask_in[31:0], dest_in[63:32], gateway_in[95:64], port[99:96],
    // position[103:100], lookup_addr[135:104]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]           s_axis_tuser,
    // master side
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // found[0], out_port[4:1], next_hop[36:5], status[38:37], zero pad[39]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // sequencer state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;

    // captured transaction
    kind_t              kind_reg;
    entry_t             new_entry_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [ADDR_W-1:0]  addr_reg;

    // pending result and output register
    result_t            res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // store ports
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;

    // compare unit
    logic               hit;
    logic [ADDR_W-1:0]  hop;

    // helpers
    logic               s_fire;
    logic               out_free;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CNT_W-1:0]   pos_cnt;
    logic [CNT_W-1:0]   idx_p1;
    logic [CNT_W-1:0]   idx_p2;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_cnt = CNT_W'(pos_reg);      // only used once pos < count
    assign idx_p1  = idx_reg + CNT_W'(1);
    assign idx_p2  = idx_reg + CNT_W'(2);

    mrt_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data)
    );

    mrt_match u_match (
        .entry (rd_data),
        .addr  (addr_reg),
        .hit   (hit),
        .hop   (hop)
    );

    // capture of the accepted transaction, plus the result, output and index registers; no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg              <= kind_t'(s_axis_tuser);
            new_entry_reg.mask    <= s_axis_tdata[31:0];
            new_entry_reg.dest    <= s_axis_tdata[63:32];
            new_entry_reg.gateway <= s_axis_tdata[95:64];
            new_entry_reg.port    <= s_axis_tdata[99:96];
            pos_reg               <= s_axis_tdata[103:100];
            addr_reg              <= s_axis_tdata[135:104];
        end
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        idx_reg    <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = new_entry_reg;
        rd_addr      = '0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                res_next   = '{found: 1'b0, out_port: '0, next_hop: '0, status: ST_OK};
                state_next = S_SEND;
                idx_next   = '0;
                unique case (kind_reg)
                    KIND_ADD: begin
                        if (count_reg == DEPTH_C) begin
                            res_next.status = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    KIND_REMOVE: begin
                        if (pos_ext >= cnt_ext) begin
                            res_next.status = ST_RANGE;
                        end else if (pos_ext + CMP_W'(1) == cnt_ext) begin
                            // last entry: nothing to move
                            count_next = count_reg - CNT_W'(1);
                        end else begin
                            idx_next   = pos_cnt;
                            rd_addr    = IDX_W'(pos_cnt + CNT_W'(1));
                            state_next = S_SHIFT;
                        end
                    end
                    KIND_LOOKUP: begin
                        if (count_reg != '0) begin
                            rd_addr    = '0;
                            state_next = S_SCAN;
                        end
                    end
                    KIND_CLEAR: begin
                        count_next = '0;
                    end
                    default: ;
                endcase
            end

            S_SHIFT: begin
                // rd_data holds entry idx+1; move it down to idx
                wr_en   = 1'b1;
                wr_addr = idx_reg[IDX_W-1:0];
                wr_data = rd_data;
                if (idx_p2 == count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_SEND;
                end else begin
                    idx_next = idx_p1;
                    rd_addr  = idx_p2[IDX_W-1:0];
                end
            end

            S_SCAN: begin
                // rd_data holds entry idx
                if (hit) begin
                    res_next.found    = 1'b1;
                    res_next.out_port = rd_data.port;
                    res_next.next_hop = hop;
                    state_next        = S_SEND;
                end else if (idx_p1 == count_reg) begin
                    state_next = S_SEND;
                end else begin
                    idx_next = idx_p1;
                    rd_addr  = idx_p1[IDX_W-1:0];
                end
            end

            S_SEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, res_reg.status, res_reg.next_hop,
                                    res_reg.out_port, res_reg.found};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> idx_reg < count_reg)
        else $error("scan index past last entry");

    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> idx_p1 < count_reg)
        else $error("shift source past last entry");

    a_fire_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == S_DISPATCH)
        else $error("accepted transaction not dispatched");

    a_result_from_send: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_SEND)
        else $error("result raised outside send state");

endmodule

`default_nettype wire

// File: design/mrt_store.sv
// Route entry store: one write port, one read port with registered data.
// Depends on mrt_pkg (entry_t).
`default_nettype none

module mrt_store
    import mrt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned IDX_W       = 4
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data_reg
);

    entry_t table_reg [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= table_reg[rd_addr];
    end

endmodule

`default_nettype wire

// File: design/mrt_match.sv
// Shared compare unit: masked destination match and next-hop select for one
// entry per cycle. Depends on mrt_pkg (entry_t).
`default_nettype none

module mrt_match
    import mrt_pkg::*;
(
    input  wire entry_t            entry,
    input  wire logic [ADDR_W-1:0] addr,
    output logic                   hit,
    output logic [ADDR_W-1:0]      hop
);

    // equal under mask when no masked bit differs
    assign hit = (((addr ^ entry.dest) & entry.mask) == '0);
    assign hop = (entry.gateway == '0) ? addr : entry.gateway;

endmodule

`default_nettype wire
